FILE: rtl/mde_pkg.sv
// Shared constants, types and table generators for the multiband dynamic equalizer.
// Used by the channel interfaces and by the core; depends on nothing else.
`default_nettype none
package mde_pkg;

    localparam int NUM_BANDS       = 4;
    localparam int MAX_BANDS       = 4;
    localparam int SAMPLE_BITS     = 24;
    localparam int LOG_TABLE_DEPTH = 64;

    localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int LOG_IDX_W = $clog2(LOG_TABLE_DEPTH);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_REGS   = 2 * NUM_BANDS;

    localparam int GAIN_W = 17;
    localparam int Y_W    = 28;
    localparam int ENV_W  = 28;
    localparam int DB_W   = 16;
    localparam int COEF_W = 18;

    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = (SAMPLE_BITS + 1 > 29) ? SAMPLE_BITS + 1 : 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WK_W    = PROD_W + 2;
    localparam int ACC_W   = ((PROD_W > SAMPLE_BITS + 16) ? PROD_W : SAMPLE_BITS + 16) + 3;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);
    localparam int DB_PER_LOG2 = 394566;
    localparam int LOG2_PER_DB = 10885;

    typedef logic [LOG_TABLE_DEPTH-1:0][GAIN_W-1:0] lut_t;

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[63:0], n[k]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] frac_log2(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] x;
        logic [15:0] r;
        x = udiv64(num << 30, den);
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= 64'h8000_0000)
            begin
                r[0] = 1'b1;
                x = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic lut_t make_log_tab();
        lut_t t;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++)
        begin
            t[i] = {1'b0, frac_log2(64'(LOG_TABLE_DEPTH + i), 64'(LOG_TABLE_DEPTH))};
        end
        return t;
    endfunction

    function automatic lut_t make_exp_tab();
        lut_t t;
        logic [63:0] lim;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++)
        begin
            lim = (64'(i) << 16) >> LOG_IDX_W;
            lo = 64'd32769;
            hi = 64'd65536;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (64'(frac_log2(64'd65536, mid)) <= lim)
                    hi = mid;
                else
                    lo = mid + 64'd1;
            end
            t[i] = GAIN_W'(lo);
        end
        return t;
    endfunction

    localparam lut_t LOG_TAB = make_log_tab();
    localparam lut_t EXP_TAB = make_exp_tab();

endpackage
`default_nettype wire

FILE: rtl/mde_if.sv
// Valid/ready channel interfaces for samples in, results out and register writes.
// Depends on mde_pkg for the field widths.
`default_nettype none
interface mde_in_if;
    import mde_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          frame_start;
    modport source (output valid, sample_in, frame_start, input ready);
    modport sink (input valid, sample_in, frame_start, output ready);
endinterface

interface mde_out_if;
    import mde_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GAIN_W-1:0]             peak_reduction;
    logic [GAIN_W-1:0]             gain_band0;
    logic [GAIN_W-1:0]             gain_band1;
    logic [GAIN_W-1:0]             gain_band2;
    logic [GAIN_W-1:0]             gain_band3;
    modport source (output valid, sample_out, peak_reduction, gain_band0, gain_band1,
                    gain_band2, gain_band3, input ready);
    modport sink (input valid, sample_out, peak_reduction, gain_band0, gain_band1,
                  gain_band2, gain_band3, output ready);
endinterface

interface mde_cfg_if;
    import mde_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/multiband_dynamic_eq_core.sv
// Each accepted beat on src holds one sample. The sample goes through four bands one after
// the other, each a bandpass biquad, a peak envelope follower and a compression gain, all on
// one shared 20 x 29 bit signed multiplier run by a sequencer. A band whose level is not above
// threshold skips the reduction steps and keeps unity gain. src is ready only between samples.
// The finished result sits in an output register, so the next sample is taken while the last
// result still waits on dst. The user must write registers through cfg only while the block is
// idle; the block itself does not enforce this. cfg is always ready.
// Depends on mde_pkg and the channel interfaces in mde_if.
`default_nettype none
module multiband_dynamic_eq_core (
    input  wire           clk,
    input  wire           rst_n,
    mde_in_if.sink        src,
    mde_out_if.source     dst,
    mde_cfg_if.sink       cfg
);
    import mde_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_F0, S_F1, S_F2, S_F3, S_Y, S_E0, S_E1, S_E2, S_E3,
        S_N, S_L, S_D, S_R0, S_R1, S_G, S_ACC, S_A2, S_OUT
    } state_t;

    localparam logic signed [WK_W-1:0] Y_HI = WK_W'((64'sd1 <<< (Y_W - 1)) - 64'sd1);
    localparam logic signed [WK_W-1:0] Y_LO = -(WK_W'(64'sd1 <<< (Y_W - 1)));
    localparam logic signed [ACC_W-1:0] O_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] O_LO = -(ACC_W'(64'sd1 <<< (SAMPLE_BITS - 1)));

    state_t                        state_reg;
    logic [BAND_W-1:0]             band_reg;
    logic [2:0]                    step_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg [NUM_BANDS];
    logic signed [SAMPLE_BITS-1:0] x2_reg [NUM_BANDS];
    logic signed [Y_W-1:0]         y1_reg [NUM_BANDS];
    logic signed [Y_W-1:0]         y2_reg [NUM_BANDS];
    logic [ENV_W-1:0]              env_reg [NUM_BANDS];
    logic [CFG_DATA_W-1:0]         filt_reg [NUM_BANDS];
    logic [CFG_DATA_W-1:0]         dyn_reg [NUM_BANDS];
    logic signed [WK_W-1:0]        wk_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [Y_W-1:0]         y_reg;
    logic [ENV_W-1:0]              a_reg;
    logic [ENV_W-1:0]              norm_reg;
    logic [4:0]                    lz_reg;
    logic [16:0]                   over_reg;
    logic [GAIN_W-1:0]             g_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [GAIN_W-1:0]             peak_reg;
    logic [GAIN_W-1:0]             gain_reg [MAX_BANDS];
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [GAIN_W-1:0]             out_peak_reg;
    logic [GAIN_W-1:0]             out_gain_reg [MAX_BANDS];
    logic                          out_valid_reg;

    logic [CFG_DATA_W-1:0]         f_cur;
    logic [CFG_DATA_W-1:0]         d_cur;
    logic [ENV_W-1:0]              env_cur;
    logic [15:0]                   c_sel;
    logic signed [SAMPLE_BITS:0]   xd;
    logic signed [21:0]            l2;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      mul_p;
    logic signed [WK_W-1:0]        ys;
    logic signed [Y_W-1:0]         y_new;
    logic [WK_W-1:0]               env_sum;
    logic [ENV_W-1:0]              env_new;
    logic [4:0]                    sh;
    logic signed [PROD_W-1:0]      dbw;
    logic signed [DB_W-1:0]        db;
    logic signed [DB_W:0]          over_d;
    logic [5:0]                    n_sh;
    logic [GAIN_W-1:0]             g_new;
    logic signed [ACC_W-1:0]       os;
    logic signed [SAMPLE_BITS-1:0] o_sat;
    logic                          accept;

    assign accept    = src.valid && src.ready;
    assign src.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign dst.valid          = out_valid_reg;
    assign dst.sample_out     = out_sample_reg;
    assign dst.peak_reduction = out_peak_reg;
    assign dst.gain_band0     = out_gain_reg[0];
    assign dst.gain_band1     = out_gain_reg[1];
    assign dst.gain_band2     = out_gain_reg[2];
    assign dst.gain_band3     = out_gain_reg[3];

    always_comb
    begin
        f_cur   = filt_reg[band_reg];
        d_cur   = dyn_reg[band_reg];
        env_cur = env_reg[band_reg];
        c_sel   = (a_reg > env_cur) ? d_cur[47:32] : d_cur[63:48];
        xd      = (SAMPLE_BITS + 1)'(x_reg) - (SAMPLE_BITS + 1)'(x2_reg[band_reg]);
        l2      = {6'sd4 - $signed({1'b0, lz_reg}),
                   LOG_TAB[norm_reg[ENV_W-2 -: LOG_IDX_W]][15:0]};

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_F0:
            begin
                mul_a = MUL_A_W'($signed(f_cur[17:0]));
                mul_b = MUL_B_W'(xd);
            end
            S_F1:
            begin
                mul_a = MUL_A_W'($signed(f_cur[35:18]));
                mul_b = MUL_B_W'(y1_reg[band_reg]);
            end
            S_F2:
            begin
                mul_a = MUL_A_W'($signed(f_cur[53:36]));
                mul_b = MUL_B_W'(y2_reg[band_reg]);
            end
            S_E0:
            begin
                mul_a = MUL_A_W'($signed({1'b0, c_sel}));
                mul_b = MUL_B_W'($signed({1'b0, env_cur}));
            end
            S_E1:
            begin
                mul_a = MUL_A_W'($signed(18'd65536 - {2'b0, c_sel}));
                mul_b = MUL_B_W'($signed({1'b0, a_reg}));
            end
            S_L:
            begin
                mul_a = MUL_A_W'(DB_PER_LOG2);
                mul_b = MUL_B_W'(l2);
            end
            S_R0:
            begin
                mul_a = MUL_A_W'($signed(18'd65536 - {2'b0, d_cur[31:16]}));
                mul_b = MUL_B_W'($signed({1'b0, over_reg}));
            end
            S_R1:
            begin
                mul_a = MUL_A_W'(LOG2_PER_DB);
                mul_b = MUL_B_W'($signed({1'b0, prod_reg[31:16]}));
            end
            S_ACC:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_reg}) - $signed({1'b0, UNITY_GAIN}));
                mul_b = MUL_B_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

        ys = (wk_reg + WK_W'(32768)) >>> 16;
        priority if (ys > Y_HI)
            y_new = Y_W'(Y_HI);
        else if (ys < Y_LO)
            y_new = Y_W'(Y_LO);
        else
            y_new = Y_W'(ys);

        env_sum = wk_reg + WK_W'(32768);
        env_new = env_sum[ENV_W+15:16];
        sh      = 5'd16 >> step_reg;

        dbw = prod_reg >>> 24;
        priority if (dbw > PROD_W'(32767))
            db = 16'sh7fff;
        else if (dbw < -PROD_W'(32768))
            db = -16'sh8000;
        else
            db = DB_W'(dbw);
        over_d = (DB_W + 1)'(db) - (DB_W + 1)'($signed(d_cur[15:0]));

        n_sh  = prod_reg[29:24];
        g_new = (n_sh >= 6'd17) ? '0 : (EXP_TAB[prod_reg[23 -: LOG_IDX_W]] >> n_sh);

        os = (acc_reg + ACC_W'(32768)) >>> 16;
        priority if (os > O_HI)
            o_sat = SAMPLE_BITS'(O_HI);
        else if (os < O_LO)
            o_sat = SAMPLE_BITS'(O_LO);
        else
            o_sat = SAMPLE_BITS'(os);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                filt_reg[b] <= '0;
                dyn_reg[b]  <= '0;
            end
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_REGS))
        begin
            if (cfg.index[0])
                dyn_reg[cfg.index[BAND_W:1]] <= cfg.data;
            else
                filt_reg[cfg.index[BAND_W:1]] <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            band_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                x1_reg[b]  <= '0;
                x2_reg[b]  <= '0;
                y1_reg[b]  <= '0;
                y2_reg[b]  <= '0;
                env_reg[b] <= '0;
            end
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                gain_reg[b]     <= UNITY_GAIN;
                out_gain_reg[b] <= UNITY_GAIN;
            end
        end
        else
        begin
            prod_reg <= mul_p;
            if (dst.valid && dst.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg    <= src.sample_in;
                        acc_reg  <= ACC_W'(src.sample_in) <<< 16;
                        band_reg <= '0;
                        if (src.frame_start)
                        begin
                            peak_reg <= '0;
                            for (int b = 0; b < NUM_BANDS; b++)
                            begin
                                x1_reg[b] <= '0;
                                x2_reg[b] <= '0;
                                y1_reg[b] <= '0;
                                y2_reg[b] <= '0;
                            end
                        end
                        state_reg <= S_F0;
                    end
                end
                S_F0:
                    state_reg <= S_F1;
                S_F1:
                begin
                    wk_reg    <= WK_W'(prod_reg);
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    wk_reg    <= wk_reg - WK_W'(prod_reg);
                    state_reg <= S_F3;
                end
                S_F3:
                begin
                    wk_reg    <= wk_reg - WK_W'(prod_reg);
                    state_reg <= S_Y;
                end
                S_Y:
                begin
                    y_reg            <= y_new;
                    a_reg            <= y_new[Y_W-1] ? ENV_W'(-((Y_W + 1)'(y_new)))
                                                     : ENV_W'(y_new);
                    x2_reg[band_reg] <= x1_reg[band_reg];
                    x1_reg[band_reg] <= x_reg;
                    y2_reg[band_reg] <= y1_reg[band_reg];
                    y1_reg[band_reg] <= y_new;
                    state_reg        <= S_E0;
                end
                S_E0:
                    state_reg <= S_E1;
                S_E1:
                begin
                    wk_reg    <= WK_W'(prod_reg);
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    wk_reg    <= wk_reg + WK_W'(prod_reg);
                    state_reg <= S_E3;
                end
                S_E3:
                begin
                    env_reg[band_reg] <= env_new;
                    norm_reg          <= (env_new == '0) ? ENV_W'(1) : env_new;
                    lz_reg            <= '0;
                    step_reg          <= '0;
                    state_reg         <= S_N;
                end
                S_N:
                begin
                    if ((norm_reg >> (ENV_W - int'(sh))) == '0)
                    begin
                        norm_reg <= norm_reg << sh;
                        lz_reg   <= lz_reg + sh;
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4)
                        state_reg <= S_L;
                end
                S_L:
                    state_reg <= S_D;
                S_D:
                begin
                    if (db <= $signed(d_cur[15:0]))
                    begin
                        g_reg     <= UNITY_GAIN;
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        over_reg  <= 17'(over_d);
                        state_reg <= S_R0;
                    end
                end
                S_R0:
                    state_reg <= S_R1;
                S_R1:
                    state_reg <= S_G;
                S_G:
                begin
                    g_reg     <= g_new;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    gain_reg[band_reg] <= g_reg;
                    if (UNITY_GAIN - g_reg > peak_reg)
                        peak_reg <= UNITY_GAIN - g_reg;
                    state_reg <= S_A2;
                end
                S_A2:
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (band_reg == BAND_W'(NUM_BANDS - 1))
                        state_reg <= S_OUT;
                    else
                    begin
                        band_reg  <= band_reg + 1'b1;
                        state_reg <= S_F0;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || dst.ready)
                    begin
                        out_sample_reg <= o_sat;
                        out_peak_reg   <= peak_reg;
                        for (int b = 0; b < MAX_BANDS; b++)
                            out_gain_reg[b] <= gain_reg[b];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_F0) && (band_reg == '0))
        else $error("sample accepted without starting band 0");

    a_last_band_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A2) && (band_reg == BAND_W'(NUM_BANDS - 1)) |=> state_reg == S_OUT)
        else $error("last band did not lead to the result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && !out_valid_reg |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("free output register was not loaded");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_N) || (state_reg == S_L) |-> norm_reg != '0)
        else $error("normalizer operand is zero");

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> out_peak_reg <= UNITY_GAIN)
        else $error("peak reduction beyond unity");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for multiband_dynamic_eq_core: random and directed samples are
// driven through valid/ready channels, and each result is checked against a built-in model.
// Depends on mde_pkg and the channel interfaces in mde_if.
`timescale 1ns / 100ps
module tb;
    import mde_pkg::*;

    localparam int NREG = 2 * MAX_BANDS;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [GAIN_W-1:0]             peak;
        logic [GAIN_W-1:0]             gain [MAX_BANDS];
    } eq_result_t;

    logic clk;
    logic rst_n;

    mde_in_if  src ();
    mde_out_if dst ();
    mde_cfg_if cfg ();

    multiband_dynamic_eq_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src.sink),
        .dst   (dst.source),
        .cfg   (cfg.sink)
    );

    int unsigned log_lut [LOG_TABLE_DEPTH];
    int unsigned exp_lut [LOG_TABLE_DEPTH];
    logic [63:0] band_regs [NREG];
    longint      x_hist [MAX_BANDS][2];
    longint      y_hist [MAX_BANDS][2];
    int unsigned env_level [MAX_BANDS];
    int unsigned peak_level;

    eq_result_t pending_results [$];
    int         error_count;
    int         samples_sent;
    int         results_seen;
    bit         steady_flow;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned log2_fraction(longint unsigned num, longint unsigned den);
        longint unsigned x;
        int unsigned r;
        x = (num << 30) / den;
        r = 0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31))
            begin
                r = r | 1;
                x = x >> 1;
            end
        end
        return r & 32'hFFFF;
    endfunction

    function automatic void build_luts();
        int unsigned lim;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++)
        begin
            lim = (i * 65536) / LOG_TABLE_DEPTH;
            lo = 32769;
            hi = 65536;
            log_lut[i] = log2_fraction(LOG_TABLE_DEPTH + i, LOG_TABLE_DEPTH);
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (log2_fraction(65536, mid) <= lim)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            exp_lut[i] = lo;
        end
    endfunction

    function automatic void clear_state();
        for (int b = 0; b < MAX_BANDS; b++)
        begin
            x_hist[b][0] = 0;
            x_hist[b][1] = 0;
            y_hist[b][0] = 0;
            y_hist[b][1] = 0;
            env_level[b] = 0;
        end
        for (int i = 0; i < NREG; i++)
            band_regs[i] = '0;
        peak_level = 0;
    endfunction

    function automatic int unsigned level_to_gain(int unsigned level, logic [63:0] dyn);
        longint unsigned e;
        longint unsigned frac;
        longint unsigned red;
        longint unsigned rl;
        longint unsigned invc;
        longint l2;
        longint db;
        longint thr;
        longint over;
        int p;
        int unsigned n;
        e = (level != 0) ? level : 1;
        p = 0;
        while (p < 63 && (e >> (p + 1)) != 0)
            p++;
        frac = ((e << 16) >> p) & 64'hFFFF;
        l2 = (longint'(p) - 23) * 65536 + longint'(log_lut[(frac * LOG_TABLE_DEPTH) >> 16]);
        db = (l2 * DB_PER_LOG2) >>> 24;
        if (db < -32768)
            db = -32768;
        if (db > 32767)
            db = 32767;
        thr = longint'($signed(dyn[15:0]));
        if (db <= thr)
            return 65536;
        over = db - thr;
        invc = 65536 - longint'(dyn[31:16]);
        red = (longint'(over) * invc) >> 16;
        rl = (red * LOG2_PER_DB) >> 8;
        n = int'(rl >> 16);
        if (n >= 17)
            return 0;
        return exp_lut[((rl & 64'hFFFF) * LOG_TABLE_DEPTH) >> 16] >> n;
    endfunction

    function automatic eq_result_t equalize_sample(logic signed [SAMPLE_BITS-1:0] sin,
                                                   logic fs);
        eq_result_t r;
        longint x;
        longint acc;
        longint s;
        longint y;
        longint b0;
        longint a1;
        longint a2;
        longint unsigned mag;
        longint unsigned c;
        longint smax;
        logic [63:0] f;
        logic [63:0] dyn;
        int unsigned g;
        x = longint'(sin);
        acc = x * 65536;
        smax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        if (fs)
        begin
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                x_hist[b][0] = 0;
                x_hist[b][1] = 0;
                y_hist[b][0] = 0;
                y_hist[b][1] = 0;
            end
            peak_level = 0;
        end
        for (int b = 0; b < MAX_BANDS; b++)
            r.gain[b] = GAIN_W'(65536);
        for (int b = 0; b < NUM_BANDS && b < MAX_BANDS; b++)
        begin
            f = band_regs[2 * b];
            dyn = band_regs[2 * b + 1];
            b0 = longint'($signed(f[17:0]));
            a1 = longint'($signed(f[35:18]));
            a2 = longint'($signed(f[53:36]));
            s = b0 * (x - x_hist[b][1]) - a1 * y_hist[b][0] - a2 * y_hist[b][1];
            y = (s + 32768) >>> 16;
            if (y > 134217727)
                y = 134217727;
            if (y < -134217728)
                y = -134217728;
            x_hist[b][1] = x_hist[b][0];
            x_hist[b][0] = x;
            y_hist[b][1] = y_hist[b][0];
            y_hist[b][0] = y;
            mag = (y < 0) ? -y : y;
            c = (mag > longint'(env_level[b])) ? dyn[47:32] : dyn[63:48];
            env_level[b] = int'((c * env_level[b] + (65536 - c) * mag + 32768) >> 16);
            g = level_to_gain(env_level[b], dyn);
            r.gain[b] = GAIN_W'(g);
            acc += y * (longint'(g) - 65536);
            if (65536 - g > peak_level)
                peak_level = 65536 - g;
        end
        acc = (acc + 32768) >>> 16;
        if (acc > smax)
            acc = smax;
        if (acc < -smax - 1)
            acc = -smax - 1;
        r.sample = SAMPLE_BITS'(acc);
        r.peak = GAIN_W'(peak_level);
        return r;
    endfunction

    function automatic bit take_break();
        return !steady_flow && ($urandom_range(0, 99) < 38);
    endfunction

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sin, logic fs);
        while (take_break())
        begin
            src.valid <= 1'b0;
            @(posedge clk);
        end
        src.valid       <= 1'b1;
        src.sample_in   <= sin;
        src.frame_start <= fs;
        do
            @(posedge clk);
        while (!src.ready);
        pending_results.push_back(equalize_sample(sin, fs));
        samples_sent++;
    endtask

    task automatic write_reg(int idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_IDX_W'(idx);
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx < NREG)
            band_regs[idx] = value;
    endtask

    task automatic wait_drained();
        src.valid <= 1'b0;
        cfg.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        eq_result_t exp_r;
        if (rst_n && dst.valid && dst.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, sample_out %0d",
                         $time, dst.sample_out);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (dst.sample_out !== exp_r.sample)
                begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             exp_r.sample, dst.sample_out);
                    error_count++;
                end
                if (dst.peak_reduction !== exp_r.peak)
                begin
                    $display("%0t: peak_reduction expected %0d actual %0d", $time,
                             exp_r.peak, dst.peak_reduction);
                    error_count++;
                end
                if (dst.gain_band0 !== exp_r.gain[0])
                begin
                    $display("%0t: gain_band0 expected %0d actual %0d", $time,
                             exp_r.gain[0], dst.gain_band0);
                    error_count++;
                end
                if (dst.gain_band1 !== exp_r.gain[1])
                begin
                    $display("%0t: gain_band1 expected %0d actual %0d", $time,
                             exp_r.gain[1], dst.gain_band1);
                    error_count++;
                end
                if (dst.gain_band2 !== exp_r.gain[2])
                begin
                    $display("%0t: gain_band2 expected %0d actual %0d", $time,
                             exp_r.gain[2], dst.gain_band2);
                    error_count++;
                end
                if (dst.gain_band3 !== exp_r.gain[3])
                begin
                    $display("%0t: gain_band3 expected %0d actual %0d", $time,
                             exp_r.gain[3], dst.gain_band3);
                    error_count++;
                end
            end
        end
        dst.ready <= !take_break();
    end

    function automatic logic [63:0] random_filter();
        int unsigned a2;
        int a1;
        int b0;
        a2 = $urandom_range(0, 62259);
        a1 = $urandom_range(0, 65536 + a2 - 2000);
        if ($urandom_range(0, 1))
            a1 = -a1;
        b0 = $urandom_range(0, 40000);
        if ($urandom_range(0, 1))
            b0 = -b0;
        return {10'($urandom), 18'(a2), 18'(a1), 18'(b0)};
    endfunction

    function automatic logic [63:0] random_dynamics();
        int thr;
        thr = -int'($urandom_range(0, 12800));
        return {16'($urandom), 16'($urandom_range(0, 8000)), 16'($urandom), 16'(thr)};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        return v >>> $urandom_range(0, 20);
    endfunction

    task automatic test_reset_registers();
        for (int i = NREG; i < 16; i++)
            write_reg(i, {$urandom, $urandom});
        cfg.valid <= 1'b0;
        send_sample(24'sh7FFFFF, 1'b1);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh000000, 1'b0);
        send_sample(-24'sh000001, 1'b1);
        send_sample(24'sh000001, 1'b0);
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        for (int b = 0; b < MAX_BANDS; b++)
            write_reg(2 * b, {10'd0, 18'sd52429, -18'sd104858, 18'sd60000});
        write_reg(1, {16'd0, 16'd0, 16'd0, 16'h8000});
        write_reg(3, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF});
        write_reg(5, {16'd0, 16'd0, 16'hFFFF, 16'hEC00});
        write_reg(7, random_dynamics());
        cfg.valid <= 1'b0;
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? -24'sh800000 : 24'sh7FFFFF, i == 4);
        send_sample(24'sh000000, 1'b1);
        wait_drained();
    endtask

    task automatic test_all_ones();
        for (int i = 0; i < NREG; i++)
            write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg.valid <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_sample(random_sample(), i == 3);
        wait_drained();
    endtask

    task automatic test_random_audio(int count, bit loud);
        int left;
        int len;
        for (int b = 0; b < MAX_BANDS; b++)
        begin
            write_reg(2 * b, random_filter());
            write_reg(2 * b + 1, loud ? {16'($urandom), 16'($urandom), 16'($urandom),
                                         16'h8000 + 16'($urandom_range(0, 4096))}
                                      : random_dynamics());
        end
        cfg.valid <= 1'b0;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = $urandom_range(8, 40);
                for (int i = 0; i < len && left > 0; i++, left--)
                    send_sample(loud ? SAMPLE_BITS'($urandom) : random_sample(), i == 0);
            end
            else
            begin
                send_sample(SAMPLE_BITS'($urandom), 1'(($urandom_range(0, 3)) == 0));
                left--;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        src.valid       = 1'b0;
        src.sample_in   = '0;
        src.frame_start = 1'b0;
        dst.ready       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        error_count     = 0;
        samples_sent    = 0;
        results_seen    = 0;
        steady_flow     = 1'b0;
        build_luts();
        clear_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_gain_extremes();
        test_all_ones();
        test_random_audio(130, 1'b0);
        steady_flow = 1'b1;
        test_random_audio(130, 1'b0);
        steady_flow = 1'b0;
        test_random_audio(130, 1'b1);
        test_random_audio(130, 1'b0);
        test_random_audio(130, 1'b1);

        $display("Sent %0d samples over directed and random register settings, %0d results checked.",
                 samples_sent, results_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results still expected.", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/mde_pkg.sv
rtl/mde_if.sv
rtl/multiband_dynamic_eq_core.sv
tb/tb.sv
